/* hw/rtl/rcast_pkg.sv */
// shared constants for the nearest wall hit select block
`timescale 1ns / 1ps
`default_nettype none
package rcast_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int FRAC_BITS_DEFAULT  = 8;
   localparam int CELL_BITS          = 12;
   localparam int DIM_BITS           = 11;
   localparam int DIST_BITS          = 26;
   localparam int CSR_INDEX_BITS     = 1;
   localparam int PRE_STAGES         = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAP_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAP_HEIGHT = 1'b1;

   localparam logic [DIM_BITS-1:0] MAP_DIM_RESET = 11'd1024;

endpackage
`default_nettype wire

/* hw/rtl/rcast_if.sv */
// ray item and result item channels
`timescale 1ns / 1ps
`default_nettype none
interface rcast_req_if #(
   parameter int COORD_BITS = rcast_pkg::COORD_BITS_DEFAULT
);
   logic                                   valid;
   logic                                   ready;
   logic signed [COORD_BITS-1:0]           player_x;
   logic signed [COORD_BITS-1:0]           player_y;
   logic signed [COORD_BITS-1:0]           hor_hit_x;
   logic signed [COORD_BITS-1:0]           hor_hit_y;
   logic signed [rcast_pkg::CELL_BITS-1:0] hor_cell_x;
   logic signed [rcast_pkg::CELL_BITS-1:0] hor_cell_y;
   logic signed [COORD_BITS-1:0]           ver_hit_x;
   logic signed [COORD_BITS-1:0]           ver_hit_y;
   logic signed [rcast_pkg::CELL_BITS-1:0] ver_cell_x;
   logic signed [rcast_pkg::CELL_BITS-1:0] ver_cell_y;

   modport source (
      output valid, player_x, player_y, hor_hit_x, hor_hit_y, hor_cell_x, hor_cell_y,
             ver_hit_x, ver_hit_y, ver_cell_x, ver_cell_y,
      input  ready
   );
   modport sink (
      input  valid, player_x, player_y, hor_hit_x, hor_hit_y, hor_cell_x, hor_cell_y,
             ver_hit_x, ver_hit_y, ver_cell_x, ver_cell_y,
      output ready
   );
endinterface

interface rcast_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              chose_vertical;
   logic [rcast_pkg::DIST_BITS-1:0]   hit_distance;

   modport source (
      output valid, chose_vertical, hit_distance,
      input  ready
   );
   modport sink (
      input  valid, chose_vertical, hit_distance,
      output ready
   );
endinterface
`default_nettype wire

/* hw/rtl/raycast_nearest_wall_hit_select_top.sv */
// nearest wall hit select: top level with distance pipeline and square root
//
// usage
//   req carries one cast ray: player position, the horizontal and the vertical
//   wall hit and the map cell of each; rsp returns one item per ray with the
//   chosen side and the floored fixed point distance to the chosen hit
//   csr writes set map_width (index 0) and map_height (index 1)
// throughput
//   one item per cycle while rsp accepts items; stages compute differences,
//   squares, squared distances and the pick, then ROOT_BITS = ceil((2*COORD_BITS
//   + 2 + 2*FRAC_BITS) / 2) root bits, one result bit per square root stage
// reset
//   synchronous, clears all stage valid bits and sets both map sizes to 1024
// stalls
//   each stage holds while the stage after it is full and held; empty stages
//   keep filling, so req.ready drops only once every stage holds an item
`timescale 1ns / 1ps
`default_nettype none
module raycast_nearest_wall_hit_select_top #(
   parameter int COORD_BITS = rcast_pkg::COORD_BITS_DEFAULT,
   parameter int FRAC_BITS  = rcast_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [rcast_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [rcast_pkg::DIM_BITS-1:0]        csr_wdata,
   rcast_req_if.sink                                  req,
   rcast_rsp_if.source                                rsp
);

   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int SQ_BITS    = 2 * COORD_BITS + 1;
   localparam int D2_BITS    = SQ_BITS + 1;
   localparam int ROOT_BITS  = (D2_BITS + 2 * FRAC_BITS + 1) / 2;
   localparam int RAD_BITS   = 2 * ROOT_BITS;
   localparam int REM_BITS   = ROOT_BITS + 1;
   localparam int NUM_STAGES = rcast_pkg::PRE_STAGES + ROOT_BITS;
   localparam int DIM_BITS   = rcast_pkg::DIM_BITS;
   localparam int CELL_BITS  = rcast_pkg::CELL_BITS;
   localparam int DIST_BITS  = rcast_pkg::DIST_BITS;

   // configuration
   logic [DIM_BITS-1:0] map_width_ff;
   logic [DIM_BITS-1:0] map_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= rcast_pkg::MAP_DIM_RESET;
         map_height_ff <= rcast_pkg::MAP_DIM_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rcast_pkg::CSR_MAP_WIDTH:  map_width_ff  <= csr_wdata;
            rcast_pkg::CSR_MAP_HEIGHT: map_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage valid bits and hold logic
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] stage_en;

   always_comb begin
      stage_en[NUM_STAGES-1] = rsp.ready || !valid_ff[NUM_STAGES-1];
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         stage_en[i] = stage_en[i+1] || !valid_ff[i];
      end
   end

   assign valid_in  = {valid_ff[NUM_STAGES-2:0], req.valid};
   assign req.ready = stage_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NUM_STAGES; i++) begin
            if (stage_en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // stage 1: coordinate differences and map bounds
   logic signed [DIFF_BITS-1:0] s1_hdx_ff, s1_hdy_ff, s1_vdx_ff, s1_vdy_ff;
   logic signed [DIFF_BITS-1:0] s1_hdx_in, s1_hdy_in, s1_vdx_in, s1_vdy_in;
   logic                        s1_hor_ok_ff, s1_ver_ok_ff;
   logic                        s1_hor_ok_in, s1_ver_ok_in;

   assign s1_hdx_in = DIFF_BITS'(req.player_x) - DIFF_BITS'(req.hor_hit_x);
   assign s1_hdy_in = DIFF_BITS'(req.player_y) - DIFF_BITS'(req.hor_hit_y);
   assign s1_vdx_in = DIFF_BITS'(req.player_x) - DIFF_BITS'(req.ver_hit_x);
   assign s1_vdy_in = DIFF_BITS'(req.player_y) - DIFF_BITS'(req.ver_hit_y);

   assign s1_hor_ok_in = !req.hor_cell_x[CELL_BITS-1] && !req.hor_cell_y[CELL_BITS-1]
      && (req.hor_cell_x[DIM_BITS-1:0] < map_width_ff)
      && (req.hor_cell_y[DIM_BITS-1:0] < map_height_ff);
   assign s1_ver_ok_in = !req.ver_cell_x[CELL_BITS-1] && !req.ver_cell_y[CELL_BITS-1]
      && (req.ver_cell_x[DIM_BITS-1:0] < map_width_ff)
      && (req.ver_cell_y[DIM_BITS-1:0] < map_height_ff);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_hdx_ff    <= s1_hdx_in;
         s1_hdy_ff    <= s1_hdy_in;
         s1_vdx_ff    <= s1_vdx_in;
         s1_vdy_ff    <= s1_vdy_in;
         s1_hor_ok_ff <= s1_hor_ok_in;
         s1_ver_ok_ff <= s1_ver_ok_in;
      end
   end

   // stage 2: squares
   logic signed [PROD_BITS-1:0] p_hx, p_hy, p_vx, p_vy;
   logic [SQ_BITS-1:0]          s2_hx_ff, s2_hy_ff, s2_vx_ff, s2_vy_ff;
   logic                        s2_hor_ok_ff, s2_ver_ok_ff;

   assign p_hx = s1_hdx_ff * s1_hdx_ff;
   assign p_hy = s1_hdy_ff * s1_hdy_ff;
   assign p_vx = s1_vdx_ff * s1_vdx_ff;
   assign p_vy = s1_vdy_ff * s1_vdy_ff;

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s2_hx_ff     <= p_hx[SQ_BITS-1:0];
         s2_hy_ff     <= p_hy[SQ_BITS-1:0];
         s2_vx_ff     <= p_vx[SQ_BITS-1:0];
         s2_vy_ff     <= p_vy[SQ_BITS-1:0];
         s2_hor_ok_ff <= s1_hor_ok_ff;
         s2_ver_ok_ff <= s1_ver_ok_ff;
      end
   end

   // stage 3: squared distances
   logic [D2_BITS-1:0] s3_dh_ff, s3_dv_ff;
   logic               s3_hor_ok_ff, s3_ver_ok_ff;

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s3_dh_ff     <= D2_BITS'(s2_hx_ff) + D2_BITS'(s2_hy_ff);
         s3_dv_ff     <= D2_BITS'(s2_vx_ff) + D2_BITS'(s2_vy_ff);
         s3_hor_ok_ff <= s2_hor_ok_ff;
         s3_ver_ok_ff <= s2_ver_ok_ff;
      end
   end

   // stage 4: pick the hit
   logic               s4_vert_in;
   logic [D2_BITS-1:0] s4_d2;
   logic               s4_vert_ff;
   logic [RAD_BITS-1:0] s4_rad_ff;

   assign s4_vert_in = !s3_hor_ok_ff || (s3_ver_ok_ff && !(s3_dh_ff < s3_dv_ff));
   assign s4_d2      = s4_vert_in ? s3_dv_ff : s3_dh_ff;

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s4_vert_ff <= s4_vert_in;
         s4_rad_ff  <= RAD_BITS'(s4_d2) << (2 * FRAC_BITS);
      end
   end

   // square root, one result bit per stage
   logic [RAD_BITS-1:0]  rad_ff  [ROOT_BITS];
   logic [REM_BITS-1:0]  rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];
   logic                 vert_ff [ROOT_BITS];

   for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
      logic [RAD_BITS-1:0]  rad_prev;
      logic [REM_BITS-1:0]  rem_prev;
      logic [ROOT_BITS-1:0] root_prev;
      logic                 vert_prev;
      logic [REM_BITS+1:0]  rem_try;
      logic [REM_BITS+1:0]  trial;
      logic [REM_BITS+1:0]  rem_sub;
      logic                 take;

      if (j == 0) begin : g_first
         assign rad_prev  = s4_rad_ff;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign vert_prev = s4_vert_ff;
      end else begin : g_next
         assign rad_prev  = rad_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign vert_prev = vert_ff[j-1];
      end

      assign rem_try = {rem_prev, rad_prev[RAD_BITS-1 -: 2]};
      assign trial   = {1'b0, root_prev, 2'b01};
      assign take    = rem_try >= trial;
      assign rem_sub = rem_try - trial;

      always_ff @(posedge clock) begin
         if (stage_en[rcast_pkg::PRE_STAGES + j]) begin
            rad_ff[j]  <= rad_prev << 2;
            rem_ff[j]  <= take ? rem_sub[REM_BITS-1:0] : rem_try[REM_BITS-1:0];
            root_ff[j] <= {root_prev[ROOT_BITS-2:0], take};
            vert_ff[j] <= vert_prev;
         end
      end
   end

   logic [ROOT_BITS+DIST_BITS-1:0] root_wide;

   assign root_wide        = {{DIST_BITS{1'b0}}, root_ff[ROOT_BITS-1]};
   assign rsp.valid        = valid_ff[NUM_STAGES-1];
   assign rsp.chose_vertical = vert_ff[ROOT_BITS-1];
   assign rsp.hit_distance = root_wide[DIST_BITS-1:0];

endmodule
`default_nettype wire
